// File: rtl/mips_subset_execute_unit_macros.svh
// ---------------------------------------------------------------------------
// mips_subset_execute_unit_macros
// Assertion shorthands shared by the checker files of the execute unit.
// ---------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH

// check on every clock edge outside reset
`define MSE_CHK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that also runs while reset is held
`define MSE_CHK_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/mse_pkg.sv
// ---------------------------------------------------------------------------
// mse_pkg
// Shared types, codes and constants of the MIPS subset execute unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

    localparam int DATA_WORDS_DEFAULT = 256;
    localparam int QUEUE_DEPTH        = 2;
    localparam int REG_COUNT          = 32;
    localparam int REG_AW             = $clog2(REG_COUNT);
    localparam int DIDX_W             = 14;

    localparam logic [31:0] DATA_BASE = 32'h1001_0000;
    localparam logic [31:0] PC_RESET  = 32'h0040_0000;

    localparam logic [REG_AW-1:0] ZERO_REG = 5'd0;
    localparam logic [REG_AW-1:0] AT_REG   = 5'd1;
    localparam logic [REG_AW-1:0] RA_REG   = 5'd31;

    // request kinds
    localparam logic [1:0] ITEM_EXEC = 2'd0;
    localparam logic [1:0] ITEM_LOAD = 2'd1;
    localparam logic [1:0] ITEM_READ = 2'd2;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNSUP = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // primary opcodes
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_JAL   = 6'h03;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_BNE   = 6'h05;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_ANDI  = 6'h0C;
    localparam logic [5:0] OPC_ORI   = 6'h0D;
    localparam logic [5:0] OPC_LW    = 6'h23;

    // R-type function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    typedef enum logic [4:0] {
        OP_ADD,
        OP_SUB,
        OP_AND,
        OP_OR,
        OP_SLT,
        OP_SLL,
        OP_SRL,
        OP_ADDI,
        OP_ANDI,
        OP_ORI,
        OP_BEQ,
        OP_BNE,
        OP_LW,
        OP_J,
        OP_JAL,
        OP_SKIP,
        OP_STORE,
        OP_READ,
        OP_IDLE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [REG_AW-1:0] wd;
        logic              wr;
        logic [4:0]        shamt;
        logic [31:0]       operand;
        logic [DIDX_W-1:0] didx;
        logic              drange;
        logic [1:0]        status;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/mse_ram.sv
// ---------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/mse_front.sv
// ---------------------------------------------------------------------------
// mse_front
// Accept requests and classify them into decoded queue entries.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mse_front import mse_pkg::*; #(
    parameter int DATA_WORDS = DATA_WORDS_DEFAULT
) (
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [31:0] s_instruction,
    input  wire logic [7:0]  s_data_index,
    input  wire logic [31:0] s_data_value,
    input  wire logic [4:0]  s_reg_select,
    input  wire logic        q_full,
    input  wire logic        clear_busy,
    output logic             push,
    output item_t            push_item
);

    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [15:0] imm;
    logic [31:0] imm_sext;
    logic [31:0] imm_zext;
    item_t       item;

    assign opc      = s_instruction[31:26];
    assign fn       = s_instruction[5:0];
    assign imm      = s_instruction[15:0];
    assign imm_sext = {{16{imm[15]}}, imm};
    assign imm_zext = {16'd0, imm};

    assign s_ready = !q_full && !clear_busy;
    assign push    = s_valid && s_ready;

    always_comb begin
        item         = '0;
        item.op      = OP_IDLE;
        item.status  = ST_UNSUP;
        unique case (s_opcode)
            ITEM_EXEC: begin
                item.ra     = s_instruction[25:21];
                item.rb     = s_instruction[20:16];
                item.shamt  = s_instruction[10:6];
                item.status = ST_OK;
                unique case (opc)
                    OPC_RTYPE: begin
                        item.wd = s_instruction[15:11];
                        item.wr = 1'b1;
                        unique case (fn) inside
                            FN_ADD: item.op = OP_ADD;
                            FN_SUB: item.op = OP_SUB;
                            FN_AND: item.op = OP_AND;
                            FN_OR:  item.op = OP_OR;
                            FN_SLT: item.op = OP_SLT;
                            FN_SLL: item.op = OP_SLL;
                            FN_SRL: item.op = OP_SRL;
                            FN_JR, FN_SYSCALL: begin
                                item.op = OP_SKIP;
                                item.wr = 1'b0;
                            end
                            default: begin
                                item.op     = OP_SKIP;
                                item.wr     = 1'b0;
                                item.status = ST_UNSUP;
                            end
                        endcase
                    end
                    OPC_ADDI: begin
                        item.op      = OP_ADDI;
                        item.wd      = s_instruction[20:16];
                        item.wr      = 1'b1;
                        item.operand = imm_sext;
                    end
                    OPC_ANDI: begin
                        item.op      = OP_ANDI;
                        item.wd      = s_instruction[20:16];
                        item.wr      = 1'b1;
                        item.operand = imm_zext;
                    end
                    OPC_ORI: begin
                        item.op      = OP_ORI;
                        item.wd      = s_instruction[20:16];
                        item.wr      = 1'b1;
                        item.operand = imm_zext;
                    end
                    OPC_BEQ: begin
                        item.op      = OP_BEQ;
                        item.operand = imm_sext;
                    end
                    OPC_BNE: begin
                        item.op      = OP_BNE;
                        item.operand = imm_sext;
                    end
                    OPC_LW: begin
                        item.op   = OP_LW;
                        item.wd   = s_instruction[20:16];
                        item.wr   = 1'b1;
                        item.didx = imm[15:2];
                    end
                    OPC_J: begin
                        item.op      = OP_J;
                        item.operand = {6'd0, s_instruction[25:0]};
                    end
                    OPC_JAL: begin
                        item.op      = OP_JAL;
                        item.wd      = RA_REG;
                        item.wr      = 1'b1;
                        item.operand = {6'd0, s_instruction[25:0]};
                    end
                    default: begin
                        item.op     = OP_SKIP;
                        item.status = ST_UNSUP;
                    end
                endcase
                // drop writes to $zero
                if (item.wd == ZERO_REG) begin
                    item.wr = 1'b0;
                end
            end
            ITEM_LOAD: begin
                item.op      = OP_STORE;
                item.didx    = DIDX_W'(s_data_index);
                item.operand = s_data_value;
                item.status  = ST_OK;
            end
            ITEM_READ: begin
                item.op     = OP_READ;
                item.ra     = s_reg_select;
                item.status = ST_OK;
            end
            default: begin
                item.op     = OP_IDLE;
                item.status = ST_UNSUP;
            end
        endcase
        item.drange = (32'(item.didx) < 32'(DATA_WORDS));
        if ((item.op == OP_LW || item.op == OP_STORE) && !item.drange) begin
            item.status = ST_RANGE;
        end
    end

    assign push_item = item;

endmodule

`default_nettype wire

// File: rtl/mse_queue.sv
// ---------------------------------------------------------------------------
// mse_queue
// Short FIFO of decoded entries between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mse_queue import mse_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    output logic       head_valid,
    output item_t      head_item,
    input  wire logic  pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mse_back.sv
// ---------------------------------------------------------------------------
// mse_back
// Read operands, execute, update architectural state and hold the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mse_back import mse_pkg::*; #(
    parameter int DATA_WORDS = DATA_WORDS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    output logic             clear_busy,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_next_pc,
    output logic             m_reg_written,
    output logic [4:0]       m_written_index,
    output logic [31:0]      m_result_value,
    output logic [1:0]       m_status
);

    localparam int DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam logic [DAW-1:0] LAST_WORD = DAW'(DATA_WORDS - 1);

    // architectural state
    logic [31:0]          pc_reg;
    logic [31:0]          at1_reg;
    logic [REG_COUNT-1:0] rvalid_reg;

    // clearing pass over the data store
    logic                 clr_active_reg;
    logic [DAW-1:0]       clr_addr_reg;

    // execute stage
    logic                 e_valid_reg;
    item_t                e_item_reg;
    logic                 byp_a_reg, byp_b_reg, byp_d_reg;
    logic                 val_a_reg, val_b_reg;
    logic [31:0]          byp_a_val_reg, byp_b_val_reg, byp_d_val_reg;

    // result register
    logic                 m_valid_reg;
    logic [31:0]          m_next_pc_reg;
    logic                 m_reg_written_reg;
    logic [4:0]           m_written_index_reg;
    logic [31:0]          m_result_value_reg;
    logic [1:0]           m_status_reg;

    logic                 e_fire;
    logic                 e_load;
    logic [31:0]          qa, qb, dq;
    logic                 rf_we;
    logic                 dm_we;
    logic [DAW-1:0]       dm_waddr;
    logic [31:0]          dm_wdata;
    logic [31:0]          q_didx32, e_didx32;
    logic [31:0]          opa, opb, dword;
    logic [31:0]          pc4, npc, wval, res;
    logic                 is_exec;

    assign e_fire = e_valid_reg && (!m_valid_reg || m_ready);
    assign e_load = q_valid && (!e_valid_reg || e_fire);
    assign q_pop  = e_load;

    assign clear_busy = clr_active_reg;

    assign q_didx32 = 32'(q_item.didx);
    assign e_didx32 = 32'(e_item_reg.didx);

    assign rf_we = e_fire && e_item_reg.wr && (e_item_reg.wd != AT_REG);

    always_comb begin
        dm_we    = 1'b0;
        dm_waddr = clr_addr_reg;
        dm_wdata = '0;
        if (clr_active_reg) begin
            dm_we = 1'b1;
        end else if (e_fire && e_item_reg.op == OP_STORE && e_item_reg.drange) begin
            dm_we    = 1'b1;
            dm_waddr = e_didx32[DAW-1:0];
            dm_wdata = e_item_reg.operand;
        end
    end

    mse_ram #(
        .WIDTH (32),
        .DEPTH (REG_COUNT)
    ) u_rf_a (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (e_item_reg.wd),
        .wdata (wval),
        .re    (e_load),
        .raddr (q_item.ra),
        .rdata (qa)
    );

    mse_ram #(
        .WIDTH (32),
        .DEPTH (REG_COUNT)
    ) u_rf_b (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (e_item_reg.wd),
        .wdata (wval),
        .re    (e_load),
        .raddr (q_item.rb),
        .rdata (qb)
    );

    mse_ram #(
        .WIDTH (32),
        .DEPTH (DATA_WORDS)
    ) u_dmem (
        .aclk  (aclk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (e_load),
        .raddr (q_didx32[DAW-1:0]),
        .rdata (dq)
    );

    // operand selection
    always_comb begin
        if (e_item_reg.ra == ZERO_REG) begin
            opa = '0;
        end else if (e_item_reg.ra == AT_REG) begin
            opa = (e_item_reg.op == OP_READ) ? at1_reg : DATA_BASE;
        end else if (byp_a_reg) begin
            opa = byp_a_val_reg;
        end else begin
            opa = val_a_reg ? qa : '0;
        end

        if (e_item_reg.rb == ZERO_REG) begin
            opb = '0;
        end else if (e_item_reg.rb == AT_REG) begin
            opb = DATA_BASE;
        end else if (byp_b_reg) begin
            opb = byp_b_val_reg;
        end else begin
            opb = val_b_reg ? qb : '0;
        end

        dword = byp_d_reg ? byp_d_val_reg : dq;
    end

    // execute
    always_comb begin
        pc4     = pc_reg + 32'd4;
        npc     = pc4;
        wval    = '0;
        is_exec = 1'b1;
        unique case (e_item_reg.op) inside
            OP_ADD:  wval = opa + opb;
            OP_SUB:  wval = opa - opb;
            OP_AND:  wval = opa & opb;
            OP_OR:   wval = opa | opb;
            OP_SLT:  wval = {31'd0, $signed(opa) < $signed(opb)};
            OP_SLL:  wval = opb << e_item_reg.shamt;
            OP_SRL:  wval = opb >> e_item_reg.shamt;
            OP_ADDI: wval = opa + e_item_reg.operand;
            OP_ANDI: wval = opa & e_item_reg.operand;
            OP_ORI:  wval = opa | e_item_reg.operand;
            OP_BEQ: begin
                if (opa == opb) begin
                    npc = pc_reg + {e_item_reg.operand[29:0], 2'b00};
                end
            end
            OP_BNE: begin
                if (opa != opb) begin
                    npc = pc_reg + {e_item_reg.operand[29:0], 2'b00};
                end
            end
            OP_LW:   wval = e_item_reg.drange ? dword : '0;
            OP_J:    npc = e_item_reg.operand;
            OP_JAL: begin
                wval = pc4;
                npc  = e_item_reg.operand;
            end
            OP_SKIP: wval = '0;
            OP_STORE, OP_READ, OP_IDLE: begin
                npc     = pc_reg;
                is_exec = 1'b0;
            end
            default: begin
                npc     = pc_reg;
                is_exec = 1'b0;
            end
        endcase

        if (e_item_reg.wr) begin
            res = wval;
        end else if (e_item_reg.op == OP_READ) begin
            res = opa;
        end else begin
            res = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= PC_RESET;
            at1_reg        <= '0;
            rvalid_reg     <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            e_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                if (clr_addr_reg == LAST_WORD) begin
                    clr_active_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end

            if (e_fire) begin
                pc_reg <= npc;
                if (is_exec) begin
                    at1_reg <= (e_item_reg.wr && e_item_reg.wd == AT_REG) ? wval : DATA_BASE;
                end
                if (rf_we) begin
                    rvalid_reg[e_item_reg.wd] <= 1'b1;
                end
            end

            if (e_load) begin
                e_valid_reg <= 1'b1;
            end else if (e_fire) begin
                e_valid_reg <= 1'b0;
            end

            if (e_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // capture operand sources as the next entry enters execute
    always_ff @(posedge aclk) begin
        if (e_load) begin
            e_item_reg    <= q_item;
            val_a_reg     <= rvalid_reg[q_item.ra];
            val_b_reg     <= rvalid_reg[q_item.rb];
            byp_a_reg     <= rf_we && (e_item_reg.wd == q_item.ra);
            byp_b_reg     <= rf_we && (e_item_reg.wd == q_item.rb);
            byp_a_val_reg <= wval;
            byp_b_val_reg <= wval;
            byp_d_reg     <= e_fire && (e_item_reg.op == OP_STORE) && e_item_reg.drange
                             && (e_item_reg.didx == q_item.didx);
            byp_d_val_reg <= e_item_reg.operand;
        end
        if (e_fire) begin
            m_next_pc_reg       <= npc;
            m_reg_written_reg   <= e_item_reg.wr;
            m_written_index_reg <= e_item_reg.wr ? e_item_reg.wd : ZERO_REG;
            m_result_value_reg  <= res;
            m_status_reg        <= e_item_reg.status;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_next_pc       = m_next_pc_reg;
    assign m_reg_written   = m_reg_written_reg;
    assign m_written_index = m_written_index_reg;
    assign m_result_value  = m_result_value_reg;
    assign m_status        = m_status_reg;

endmodule

`default_nettype wire

// File: rtl/mips_subset_execute_unit.sv
// ---------------------------------------------------------------------------
// mips_subset_execute_unit
// A request passes the queue, the execute stage and the result register.
// Throughput: one request per cycle while the queue has room; the execute
// stage advances each cycle the result register is free, and operand hazards
// are bypassed there. Reset: clears registers to zero and PC to 0x00400000,
// then sweeps the data store one word a cycle with s_ready held low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mips_subset_execute_unit import mse_pkg::*; #(
    parameter int DATA_WORDS = DATA_WORDS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [31:0] s_instruction,
    input  wire logic [7:0]  s_data_index,
    input  wire logic [31:0] s_data_value,
    input  wire logic [4:0]  s_reg_select,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_next_pc,
    output logic             m_reg_written,
    output logic [4:0]       m_written_index,
    output logic [31:0]      m_result_value,
    output logic [1:0]       m_status
);

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;
    logic  clear_busy;

    mse_front #(
        .DATA_WORDS (DATA_WORDS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_instruction (s_instruction),
        .s_data_index  (s_data_index),
        .s_data_value  (s_data_value),
        .s_reg_select  (s_reg_select),
        .q_full        (q_full),
        .clear_busy    (clear_busy),
        .push          (push),
        .push_item     (push_item)
    );

    mse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (q_item),
        .pop        (q_pop)
    );

    mse_back #(
        .DATA_WORDS (DATA_WORDS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .clear_busy      (clear_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_pc       (m_next_pc),
        .m_reg_written   (m_reg_written),
        .m_written_index (m_written_index),
        .m_result_value  (m_result_value),
        .m_status        (m_status)
    );

endmodule

`default_nettype wire

// File: rtl/mse_checker.sv
// ---------------------------------------------------------------------------
// mse_checker
// Port-level checks of the execute unit, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mips_subset_execute_unit_macros.svh"

module mse_checker import mse_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_next_pc,
    input wire logic        m_reg_written,
    input wire logic [4:0]  m_written_index,
    input wire logic [31:0] m_result_value,
    input wire logic [1:0]  m_status
);

    `MSE_CHK(a_hold_stalled, m_valid && !m_ready |=> m_valid && $stable(m_next_pc) && $stable(m_result_value) && $stable(m_status), "result changed while stalled")
    `MSE_CHK(a_index_written, m_valid && m_reg_written |-> m_written_index != ZERO_REG, "write reported to zero register")
    `MSE_CHK(a_index_idle, m_valid && !m_reg_written |-> m_written_index == ZERO_REG, "index set without a write")
    `MSE_CHK(a_range_zero, m_valid && m_status == ST_RANGE |-> m_result_value == 32'd0, "range fault with nonzero value")
    `MSE_CHK_RST(a_sweep_after_reset, !aresetn |=> !s_ready, "ready during store sweep")

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_next_pc       (m_next_pc),
    .m_reg_written   (m_reg_written),
    .m_written_index (m_written_index),
    .m_result_value  (m_result_value),
    .m_status        (m_status)
);

`default_nettype wire

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the MIPS subset execute unit. A shadow copy of the
// register file, program counter and data store predicts each result. A short
// directed list covers every instruction and corner case. Random traffic then
// follows, with sender bursts, receiver stall patterns and long hold-offs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import mse_pkg::*;;

    localparam int          DMEM_WORDS   = DATA_WORDS_DEFAULT;
    localparam int          RANDOM_ITEMS = 1820;
    localparam logic [1:0]  ITEM_NONE    = 2'd3;
    localparam logic [5:0]  OPC_SW       = 6'h2B;
    localparam logic [5:0]  FN_BAD       = 6'h3F;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  written_index;
        logic [31:0] result_value;
        logic [1:0]  status;
    } exec_result_t;

    typedef enum {RX_HOLD, RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

    class exec_tracker;
        logic [31:0]  gpr [32];
        logic [31:0]  pc;
        logic [31:0]  dmem [DMEM_WORDS];
        exec_result_t expected_results [$];
        int           mismatches;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            pc = PC_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void predict_request(logic [1:0] kind, logic [31:0] ins,
                                      logic [7:0] didx, logic [31:0] dval,
                                      logic [4:0] rsel);
            exec_result_t r;
            logic [5:0]   op;
            logic [5:0]   fn;
            logic [4:0]   rs;
            logic [4:0]   rt;
            logic [4:0]   rd;
            logic [4:0]   sh;
            logic [31:0]  imm_z;
            logic [31:0]  imm_s;
            logic [31:0]  a;
            logic [31:0]  b;
            logic [31:0]  npc;
            logic [31:0]  wval;
            logic [4:0]   widx;
            logic         wr;
            logic [13:0]  word;
            r = '0;
            case (kind)
                ITEM_EXEC: begin
                    op    = ins[31:26];
                    rs    = ins[25:21];
                    rt    = ins[20:16];
                    rd    = ins[15:11];
                    sh    = ins[10:6];
                    fn    = ins[5:0];
                    imm_z = {16'h0000, ins[15:0]};
                    imm_s = {{16{ins[15]}}, ins[15:0]};
                    gpr[AT_REG] = DATA_BASE;
                    a     = gpr[rs];
                    b     = gpr[rt];
                    npc   = pc + 32'd4;
                    wr    = 1'b0;
                    widx  = ZERO_REG;
                    wval  = '0;
                    case (op)
                        OPC_RTYPE: begin
                            wr   = 1'b1;
                            widx = rd;
                            case (fn)
                                FN_ADD: wval = a + b;
                                FN_SUB: wval = a - b;
                                FN_AND: wval = a & b;
                                FN_OR:  wval = a | b;
                                FN_SLT: wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                                FN_SLL: wval = b << sh;
                                FN_SRL: wval = b >> sh;
                                FN_JR, FN_SYSCALL: wr = 1'b0;
                                default: begin
                                    wr       = 1'b0;
                                    r.status = ST_UNSUP;
                                end
                            endcase
                        end
                        OPC_ADDI: begin
                            wr = 1'b1; widx = rt; wval = a + imm_s;
                        end
                        OPC_ANDI: begin
                            wr = 1'b1; widx = rt; wval = a & imm_z;
                        end
                        OPC_ORI: begin
                            wr = 1'b1; widx = rt; wval = a | imm_z;
                        end
                        OPC_BEQ: begin
                            if (a == b) npc = pc + (imm_s << 2);
                        end
                        OPC_BNE: begin
                            if (a != b) npc = pc + (imm_s << 2);
                        end
                        OPC_LW: begin
                            wr   = 1'b1;
                            widx = rt;
                            word = ins[15:2];
                            if (word < DMEM_WORDS) begin
                                wval = dmem[word];
                            end else begin
                                r.status = ST_RANGE;
                            end
                        end
                        OPC_J: begin
                            npc = {6'd0, ins[25:0]};
                        end
                        OPC_JAL: begin
                            wr   = 1'b1;
                            widx = RA_REG;
                            wval = pc + 32'd4;
                            npc  = {6'd0, ins[25:0]};
                        end
                        default: r.status = ST_UNSUP;
                    endcase
                    if (wr && widx != ZERO_REG) begin
                        gpr[widx]       = wval;
                        r.reg_written   = 1'b1;
                        r.written_index = widx;
                        r.result_value  = wval;
                    end
                    pc = npc;
                end
                ITEM_LOAD: begin
                    if (didx < DMEM_WORDS) begin
                        dmem[didx] = dval;
                    end else begin
                        r.status = ST_RANGE;
                    end
                end
                ITEM_READ: r.result_value = gpr[rsel];
                default: r.status = ST_UNSUP;
            endcase
            r.next_pc = pc;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(exec_result_t got);
            exec_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual pc %h value %h",
                         $time, got.next_pc, got.result_value);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.next_pc !== want.next_pc)
                report("next_pc", want.next_pc, got.next_pc);
            if (got.reg_written !== want.reg_written)
                report("reg_written", 32'(want.reg_written), 32'(got.reg_written));
            if (got.written_index !== want.written_index)
                report("written_index", 32'(want.written_index), 32'(got.written_index));
            if (got.result_value !== want.result_value)
                report("result_value", want.result_value, got.result_value);
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode        = ITEM_READ;
    logic [31:0] s_instruction   = '0;
    logic [7:0]  s_data_index    = '0;
    logic [31:0] s_data_value    = '0;
    logic [4:0]  s_reg_select    = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [31:0] m_next_pc;
    logic        m_reg_written;
    logic [4:0]  m_written_index;
    logic [31:0] m_result_value;
    logic [1:0]  m_status;

    exec_tracker sb;

    mips_subset_execute_unit #(.DATA_WORDS(DMEM_WORDS)) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_instruction   (s_instruction),
        .s_data_index    (s_data_index),
        .s_data_value    (s_data_value),
        .s_reg_select    (s_reg_select),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_pc       (m_next_pc),
        .m_reg_written   (m_reg_written),
        .m_written_index (m_written_index),
        .m_result_value  (m_result_value),
        .m_status        (m_status)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin : observe
        exec_result_t got;
        if (aresetn && s_valid && s_ready === 1'b1) begin
            sb.predict_request(s_opcode, s_instruction, s_data_index, s_data_value,
                               s_reg_select);
        end
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got.next_pc       = m_next_pc;
            got.reg_written   = m_reg_written;
            got.written_index = m_written_index;
            got.result_value  = m_result_value;
            got.status        = m_status;
            sb.check_result(got);
        end
    end

    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OPC_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
        return {op, target};
    endfunction

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 9) < 7) return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] random_instruction();
        int          pick;
        logic [5:0]  code;
        logic [15:0] imm;
        pick = $urandom_range(0, 99);
        imm  = 16'($urandom);
        if (pick < 40) begin
            case ($urandom_range(0, 6))
                0: code = FN_ADD;
                1: code = FN_SUB;
                2: code = FN_AND;
                3: code = FN_OR;
                4: code = FN_SLT;
                5: code = FN_SLL;
                default: code = FN_SRL;
            endcase
            return enc_r(code, pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
        end
        if (pick < 60) begin
            case ($urandom_range(0, 2))
                0: code = OPC_ADDI;
                1: code = OPC_ANDI;
                default: code = OPC_ORI;
            endcase
            return enc_i(code, pick_reg(), pick_reg(), imm);
        end
        if (pick < 70) begin
            // mostly in-range word offsets
            if ($urandom_range(0, 4) != 0) imm = {6'd0, 8'($urandom), 2'($urandom)};
            return enc_i(OPC_LW, pick_reg(), pick_reg(), imm);
        end
        if (pick < 80) begin
            code = ($urandom_range(0, 1) != 0) ? OPC_BEQ : OPC_BNE;
            return enc_i(code, pick_reg(), pick_reg(), imm);
        end
        if (pick < 84) begin
            code = ($urandom_range(0, 1) != 0) ? OPC_J : OPC_JAL;
            return enc_j(code, 26'($urandom));
        end
        if (pick < 87) begin
            code = ($urandom_range(0, 1) != 0) ? FN_JR : FN_SYSCALL;
            return enc_r(code, pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
        end
        return $urandom;
    endfunction

    task automatic send_request(logic [1:0] kind, logic [31:0] ins, logic [7:0] didx,
                                logic [31:0] dval, logic [4:0] rsel);
        s_opcode      <= kind;
        s_instruction <= ins;
        s_data_index  <= didx;
        s_data_value  <= dval;
        s_reg_select  <= rsel;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
    endtask

    task automatic send_exec(logic [31:0] ins);
        send_request(ITEM_EXEC, ins, 8'($urandom), $urandom, 5'($urandom));
    endtask

    task automatic send_load(logic [7:0] didx, logic [31:0] dval);
        send_request(ITEM_LOAD, $urandom, didx, dval, 5'($urandom));
    endtask

    task automatic send_read(logic [4:0] rsel);
        send_request(ITEM_READ, $urandom, 8'($urandom), $urandom, rsel);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin : receiver
        rx_mode_t mode;
        int       span;
        int       period;
        int       pick;
        int       segment;
        segment = 0;
        forever begin
            pick    = $urandom_range(0, 19);
            period  = $urandom_range(2, 5);
            span    = $urandom_range(20, 200);
            segment++;
            if (pick == 0 || segment % 25 == 10) begin
                mode = RX_HOLD;
                span = $urandom_range(150, 400);
            end else if (pick < 7) begin
                mode = RX_FREE;
            end else if (pick < 13) begin
                mode = RX_LIGHT;
            end else if (pick < 17) begin
                mode = RX_PERIODIC;
            end else begin
                mode = RX_HEAVY;
            end
            for (int i = 0; i < span; i++) begin
                @(posedge aclk);
                case (mode)
                    RX_HOLD:     m_ready <= 1'b0;
                    RX_FREE:     m_ready <= 1'b1;
                    RX_LIGHT:    m_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: m_ready <= (i % period != 0);
                    default:     m_ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int pick;
        int burst_left;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_read(AT_REG);
        send_load(8'd0, 32'hFFFF_FFFF);
        send_load(8'd255, 32'h8000_0001);
        send_exec(enc_i(OPC_ADDI, 5'd0, 5'd2, 16'hFFFF));
        send_exec(enc_i(OPC_ADDI, AT_REG, 5'd3, 16'h7FFF));
        send_exec(enc_r(FN_ADD, 5'd2, 5'd3, 5'd4, 5'd0));
        send_exec(enc_r(FN_SUB, 5'd0, 5'd2, 5'd5, 5'd0));
        send_exec(enc_r(FN_AND, 5'd2, 5'd3, 5'd6, 5'd0));
        send_exec(enc_r(FN_OR, 5'd5, 5'd3, 5'd7, 5'd0));
        send_exec(enc_r(FN_SLT, 5'd2, 5'd0, 5'd8, 5'd0));
        send_exec(enc_r(FN_SLL, 5'd0, 5'd2, 5'd10, 5'd31));
        send_exec(enc_r(FN_SRL, 5'd0, 5'd2, 5'd11, 5'd31));
        send_exec(enc_i(OPC_ANDI, 5'd2, 5'd12, 16'hFFFF));
        send_exec(enc_i(OPC_ORI, 5'd0, 5'd13, 16'h8000));
        send_exec(enc_r(FN_ADD, 5'd2, 5'd2, ZERO_REG, 5'd0));
        send_exec(enc_i(OPC_LW, 5'd0, 5'd14, 16'd0));
        send_exec(enc_i(OPC_LW, 5'd0, 5'd15, 16'd1020));
        send_exec(enc_i(OPC_LW, 5'd0, 5'd16, 16'd1024));
        send_exec(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'hFFFF));
        send_exec(enc_i(OPC_BNE, 5'd0, 5'd0, 16'd5));
        send_exec(enc_r(FN_JR, RA_REG, 5'd0, 5'd0, 5'd0));
        send_exec(enc_r(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
        send_exec(enc_r(FN_BAD, 5'd2, 5'd3, 5'd17, 5'd0));
        send_exec(enc_i(OPC_SW, 5'd0, 5'd2, 16'd4));
        send_exec(enc_j(OPC_J, 26'h3FF_FFFF));
        send_exec(enc_j(OPC_JAL, 26'h010_0000));
        send_read(RA_REG);
        send_request(ITEM_NONE, '1, '1, '1, '1);
        drain_results();

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 400 == 399) drain_results();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 74) begin
                send_exec(random_instruction());
            end else if (pick < 86) begin
                send_load(8'($urandom), $urandom);
            end else if (pick < 97) begin
                send_read(($urandom_range(0, 1) != 0) ? pick_reg() : 5'($urandom));
            end else begin
                send_request(ITEM_NONE, $urandom, 8'($urandom), $urandom, 5'($urandom));
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
